### design/wfba_pkg.sv
`default_nettype none
package wfba_pkg;

  // Default sizing of the free-size table.
  localparam int MaxBlocksDef = 16;
  localparam int SizeBitsDef  = 16;

  // Fixed widths of the stream fields.
  localparam int SlotW   = 4;
  localparam int AmountW = 16;
  localparam int InDataW = 24;

  localparam int ChosenW  = 4;
  localparam int SpaceW   = 16;
  localparam int OutDataW = 24;

  // Configuration port.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam int BiuW     = 5;

  typedef enum logic {
    REG_BLOCKS_IN_USE = 1'b0
  } reg_idx_t;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_REQUEST = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic load;    // write one table entry from the input beat
    logic start;   // latch the request and clear the search
    logic issue;   // read the entry at the scan index and advance it
    logic update;  // write back the chosen entry and load the result
  } wfba_cmd_t;

  typedef struct packed {
    logic last;        // the scan index points at the last entry in use
    logic limit_zero;  // no entries take part in the search
    logic out_free;    // the result register can take a new beat
  } wfba_sts_t;

endpackage
`default_nettype wire

### design/wfba_ctrl.sv
`default_nettype none
module wfba_ctrl
  import wfba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_mode,
  output logic           in_ready,
  input  wire wfba_sts_t sts,
  output wfba_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = sts.limit_zero ? S_UPDATE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last entry read is compared in this cycle.
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/wfba_dpath.sv
`default_nettype none
module wfba_dpath
  import wfba_pkg::*;
#(
  parameter int MAX_BLOCKS = MaxBlocksDef,
  parameter int SIZE_BITS  = SizeBitsDef,
  localparam int IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CntW = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wfba_cmd_t          cmd,
  output wfba_sts_t               sts,
  input  wire logic [CntW-1:0]    limit,
  input  wire logic [SlotW-1:0]   in_slot,
  input  wire logic [AmountW-1:0] in_amount,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_granted,
  output logic [ChosenW-1:0]      out_chosen,
  output logic [SpaceW-1:0]       out_space
);

  logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];

  logic [SIZE_BITS-1:0] in_size;
  logic                 slot_ok;
  logic [SIZE_BITS-1:0] req;
  logic [IdxW-1:0]      scan_idx;
  logic [SIZE_BITS-1:0] rd_data;
  logic [IdxW-1:0]      rd_idx;
  logic                 rd_vld;
  logic                 found;
  logic [IdxW-1:0]      best_idx;
  logic [SIZE_BITS-1:0] best_val;
  logic                 take;
  logic [SIZE_BITS-1:0] remain;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  assign in_size = SIZE_BITS'(in_amount);
  assign slot_ok = (32'(in_slot) < MAX_BLOCKS);
  assign remain  = best_val - req;

  // A candidate must fit; it replaces the best only when strictly larger,
  // so the lowest index wins a tie.
  assign take = rd_vld && (rd_data >= req) && (!found || (rd_data > best_val));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IdxW'(in_slot);
    wr_data = in_size;
    if (cmd.load && slot_ok) begin
      wr_en = 1'b1;
    end else if (cmd.update && found) begin
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_data = remain;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.issue) begin
      rd_data <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (cmd.start) begin
      req      <= in_size;
      scan_idx <= '0;
    end else if (cmd.issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (take) begin
      best_idx <= rd_idx;
      best_val <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.start) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_granted <= found;
      out_chosen  <= found ? ChosenW'(best_idx) : '0;
      out_space   <= found ? SpaceW'(remain) : '0;
    end
  end

  assign sts.last       = ((CntW'(scan_idx) + 1'b1) == limit);
  assign sts.limit_zero = (limit == '0);
  assign sts.out_free   = !out_valid || out_ready;

endmodule
`default_nettype wire

### design/worst_fit_block_allocator_unit.sv
`default_nettype none
// Worst-fit block allocator. The unit keeps a table of free sizes for up to
// MAX_BLOCKS memory blocks. An input beat with s_tuser low loads one block's
// size and gives no result. A beat with s_tuser high requests an allocation:
// the first blocks_in_use entries are scanned through the single read port of
// the table, one entry per cycle, and the entry with the largest free size
// that still fits the request is chosen (lowest index on a tie). The chosen
// entry is reduced by the request and one result beat reports the grant, the
// index and the remaining size. A request is accepted, then scans N entries,
// where N is blocks_in_use capped at MAX_BLOCKS, then compares the last entry
// read and then writes back; with no blocks in use it is accepted and then
// writes back. The write back waits for as long as an earlier result beat
// still sits on the master side. A new beat is accepted while a result still
// waits on the master side. Entries must be loaded before a request scans
// them. The table has no reset; blocks_in_use resets to zero, which makes
// every request fail.
module worst_fit_block_allocator_unit
  import wfba_pkg::*;
#(
  parameter int MAX_BLOCKS = MaxBlocksDef,
  parameter int SIZE_BITS  = SizeBitsDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Input stream.
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [InDataW-1:0]  s_tdata,  // block_slot[3:0], amount[19:4], zero fill
  input  wire logic                s_tuser,  // mode
  // Result stream.
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OutDataW-1:0]      m_tdata,  // chosen_block[3:0], space_left[19:4], zero fill
  output logic                     m_tuser,  // granted
  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  localparam int CntW = $clog2(MAX_BLOCKS + 1);

  logic [BiuW-1:0]    blocks_in_use;
  logic [CntW-1:0]    limit;
  logic               cfg_write;
  wfba_cmd_t          cmd;
  wfba_sts_t          sts;
  logic [ChosenW-1:0] out_chosen;
  logic [SpaceW-1:0]  out_space;

  // The register index is the address divided by four; the low bits are
  // ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= '0;
    end else if (cfg_write && (paddr[2] == REG_BLOCKS_IN_USE)) begin
      blocks_in_use <= pwdata[BiuW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BLOCKS_IN_USE) ? ApbDataW'(blocks_in_use) : '0;

  // A count above the table depth searches the whole table.
  assign limit = (32'(blocks_in_use) > MAX_BLOCKS) ? CntW'(MAX_BLOCKS)
                                                   : CntW'(blocks_in_use);

  wfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wfba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .limit       (limit),
    .in_slot     (s_tdata[SlotW-1:0]),
    .in_amount   (s_tdata[SlotW+AmountW-1:SlotW]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_granted (m_tuser),
    .out_chosen  (out_chosen),
    .out_space   (out_space)
  );

  assign m_tdata = {(OutDataW - ChosenW - SpaceW)'(0), out_space, out_chosen};

endmodule
`default_nettype wire
